// ----- rtl/core/dda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared field widths, request codes, register indexes and the step-rate type.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS   = 12;
    localparam int STEP_BITS    = 12;
    localparam int POS_BITS     = 14;
    localparam int COUNT_BITS   = 13;
    localparam int PIXEL_BITS   = 8;
    localparam int GW_BITS      = 8;
    localparam int GH_BITS      = 7;
    localparam int CELLX_BITS   = 7;
    localparam int CELLY_BITS   = 6;
    localparam int REQ_BITS     = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [GW_BITS-1:0] GRID_WIDTH_RESET  = 8'd128;
    localparam logic [GH_BITS-1:0] GRID_HEIGHT_RESET = 7'd64;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_DRAW  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Whole and fractional part of one step along an axis: |delta| / steps.
    typedef struct packed {
        logic [STEP_BITS-1:0] quot;
        logic [STEP_BITS-1:0] rem;
    } t_rate;

endpackage

// ----- rtl/core/dda_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dda_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA step divider
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module dda_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dda_pkg::STEP_BITS-1:0]  i_dividend,
    input  logic [dda_pkg::STEP_BITS-1:0]  i_divisor,
    output logic                           o_done,
    output dda_pkg::t_rate                 o_rate
);

    localparam int SB = dda_pkg::STEP_BITS;
    localparam int CNT_BITS = $clog2(SB);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(SB - 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [SB-1:0]       r_quot, n_quot;
    logic [SB-1:0]       r_rem, n_rem;
    logic [SB:0]         trial;
    logic [SB:0]         diff;
    logic                fits;

    always_comb begin
        trial  = {r_rem, r_quot[SB-1]};
        diff   = trial - {1'b0, i_divisor};
        fits   = (trial >= {1'b0, i_divisor});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quot = {r_quot[SB-2:0], fits};
            n_rem  = fits ? diff[SB-1:0] : trial[SB-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_done      = r_done;
    assign o_rate.quot = r_quot;
    assign o_rate.rem  = r_rem;

endmodule

// ----- rtl/core/dda_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA axis stepper
// Tracks one coordinate as start + trunc(i * delta / steps) with an exact
// remainder accumulator.
// ----------------------------------------------------------------------------
module dda_axis (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [dda_pkg::COORD_BITS-1:0] i_start_pos,
    input  logic                                  i_neg,
    input  logic                                  i_set_rate,
    input  dda_pkg::t_rate                        i_rate,
    input  logic [dda_pkg::STEP_BITS-1:0]         i_steps,
    input  logic                                  i_advance,
    output logic signed [dda_pkg::POS_BITS-1:0]   o_pos
);

    localparam int SB = dda_pkg::STEP_BITS;
    localparam int PB = dda_pkg::POS_BITS;

    logic signed [PB-1:0] r_pos, n_pos;
    logic [SB-1:0]        r_acc, n_acc;
    logic [SB-1:0]        r_quot, n_quot;
    logic [SB-1:0]        r_frac, n_frac;
    logic                 r_neg, n_neg;
    logic [SB:0]          sum;
    logic                 carry;
    logic [SB:0]          inc;

    always_comb begin
        sum    = {1'b0, r_acc} + {1'b0, r_frac};
        carry  = (sum >= {1'b0, i_steps});
        inc    = {1'b0, r_quot} + (SB + 1)'(carry);
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_quot = r_quot;
        n_frac = r_frac;
        n_neg  = r_neg;
        if (i_load) begin
            n_pos  = PB'(i_start_pos);
            n_acc  = '0;
            n_quot = '0;
            n_frac = '0;
            n_neg  = i_neg;
        end else if (i_set_rate) begin
            n_quot = i_rate.quot;
            n_frac = i_rate.rem;
        end else if (i_advance) begin
            n_acc = carry ? SB'(sum - {1'b0, i_steps}) : sum[SB-1:0];
            n_pos = r_neg ? r_pos - $signed(PB'(inc)) : r_pos + $signed(PB'(inc));
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_acc  <= n_acc;
        r_quot <= n_quot;
        r_frac <= n_frac;
        r_neg  <= n_neg;
    end

    assign o_pos = r_pos;

endmodule

// ----- rtl/core/dda_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Draw: unless step_count is 0, divides |dx|, then |dy|, by step_count; then steps
//   through step_count + 1 points, one frame-store write per point inside the grid.
// Clear: sweeps active width x active height cells; read: ST_READ then ST_RWAIT;
//   out-of-range read, empty clear, undefined request: answered without leaving idle.
// The result strobe lasts one cycle, no stall. One transaction at a time. After reset
//   the frame store is zeroed over all MAX_WIDTH x MAX_HEIGHT cells with busy high.
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Frame store of tile indices with exact-rational line drawing, clear, read.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int VALUE_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [dda_pkg::REQ_BITS-1:0]            i_req_type,
    input  logic signed [dda_pkg::COORD_BITS-1:0]   i_start_x,
    input  logic signed [dda_pkg::COORD_BITS-1:0]   i_start_y,
    input  logic signed [dda_pkg::COORD_BITS-1:0]   i_end_x,
    input  logic signed [dda_pkg::COORD_BITS-1:0]   i_end_y,
    input  logic [dda_pkg::STEP_BITS-1:0]           i_step_count,
    input  logic [dda_pkg::PIXEL_BITS-1:0]          i_pixel_value,
    input  logic [dda_pkg::CELLX_BITS-1:0]          i_cell_x,
    input  logic [dda_pkg::CELLY_BITS-1:0]          i_cell_y,
    input  logic                                    i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [dda_pkg::CFG_DATA_BITS-1:0]       i_cfg_wdata,
    output logic                                    o_result_valid,
    output logic [dda_pkg::PIXEL_BITS-1:0]          o_read_value,
    output logic [dda_pkg::COUNT_BITS-1:0]          o_points_written,
    output logic                                    o_read_out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XCW   = $clog2(MAX_WIDTH + 1);
    localparam int YCW   = $clog2(MAX_HEIGHT + 1);
    localparam int SB    = dda_pkg::STEP_BITS;
    localparam int CB    = dda_pkg::COORD_BITS;
    localparam int PB    = dda_pkg::POS_BITS;
    localparam int NB    = dda_pkg::COUNT_BITS;
    localparam int PXB   = dda_pkg::PIXEL_BITS;

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIVX  = 8'b0000_0100,
        ST_DIVY  = 8'b0000_1000,
        ST_DRAW  = 8'b0001_0000,
        ST_CLEAR = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_RWAIT = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [dda_pkg::GW_BITS-1:0] r_grid_width;
    logic [dda_pkg::GH_BITS-1:0] r_grid_height;
    logic [SB-1:0]              r_steps, n_steps;
    logic [SB-1:0]              r_cnt, n_cnt;
    logic [VALUE_BITS-1:0]      r_value, n_value;
    logic [SB-1:0]              r_mag_x, n_mag_x;
    logic [SB-1:0]              r_mag_y, n_mag_y;
    logic [XW-1:0]              r_cell_x, n_cell_x;
    logic [YW-1:0]              r_cell_y, n_cell_y;
    logic [XW-1:0]              r_cx, n_cx;
    logic [YW-1:0]              r_cy, n_cy;
    logic [NB-1:0]              r_points, n_points;
    logic                       r_div_kick, n_div_kick;
    logic                       r_out_valid, n_out_valid;
    logic [PXB-1:0]             r_read_value, n_read_value;
    logic [NB-1:0]              r_out_points, n_out_points;
    logic                       r_oor, n_oor;

    logic [XCW-1:0]             act_w;
    logic [YCW-1:0]             act_h;
    logic [XCW-1:0]             lim_w;
    logic [YCW-1:0]             lim_h;
    logic                       sweep_last_x;
    logic                       sweep_last_y;
    logic                       accept;
    logic [CB:0]                dx;
    logic [CB:0]                dy;
    logic                       neg_x;
    logic                       neg_y;
    logic                       read_oor;
    logic                       div_done;
    dda_pkg::t_rate             div_rate;
    logic [SB-1:0]              div_dividend;
    logic                       axis_load;
    logic                       axis_advance;
    logic signed [PB-1:0]       pos_x;
    logic signed [PB-1:0]       pos_y;
    logic                       draw_in;
    logic [XW-1:0]              ram_col;
    logic [YW-1:0]              ram_row;
    logic [AW-1:0]              ram_addr;
    logic                       ram_we;
    logic [VALUE_BITS-1:0]      ram_wdata;
    logic [VALUE_BITS-1:0]      ram_rdata;

    // Saturate the grid registers to the store size.
    assign act_w = (32'(r_grid_width) > 32'(MAX_WIDTH)) ? XCW'(MAX_WIDTH)
                                                        : XCW'(r_grid_width);
    assign act_h = (32'(r_grid_height) > 32'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT)
                                                          : YCW'(r_grid_height);

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign dx    = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
    assign dy    = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
    assign neg_x = dx[CB];
    assign neg_y = dy[CB];

    assign read_oor = (32'(i_cell_x) >= 32'(act_w)) || (32'(i_cell_y) >= 32'(act_h));

    assign lim_w = (r_state == ST_INIT) ? XCW'(MAX_WIDTH) : act_w;
    assign lim_h = (r_state == ST_INIT) ? YCW'(MAX_HEIGHT) : act_h;
    assign sweep_last_x = ((32'(r_cx) + 32'd1) == 32'(lim_w));
    assign sweep_last_y = ((32'(r_cy) + 32'd1) == 32'(lim_h));

    assign draw_in = !pos_x[PB-1] && (32'(pos_x[PB-2:0]) < 32'(act_w))
                  && !pos_y[PB-1] && (32'(pos_y[PB-2:0]) < 32'(act_h));

    assign axis_load    = accept && (i_req_type == dda_pkg::REQ_DRAW);
    assign axis_advance = (r_state == ST_DRAW) && (r_cnt != r_steps);
    assign div_dividend = (r_state == ST_DIVY) ? r_mag_y : r_mag_x;

    dda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_kick),
        .i_dividend (div_dividend),
        .i_divisor  (r_steps),
        .o_done     (div_done),
        .o_rate     (div_rate)
    );

    dda_axis u_axis_x (
        .i_clk       (i_clk),
        .i_load      (axis_load),
        .i_start_pos (i_start_x),
        .i_neg       (neg_x),
        .i_set_rate  (div_done && (r_state == ST_DIVX)),
        .i_rate      (div_rate),
        .i_steps     (r_steps),
        .i_advance   (axis_advance),
        .o_pos       (pos_x)
    );

    dda_axis u_axis_y (
        .i_clk       (i_clk),
        .i_load      (axis_load),
        .i_start_pos (i_start_y),
        .i_neg       (neg_y),
        .i_set_rate  (div_done && (r_state == ST_DIVY)),
        .i_rate      (div_rate),
        .i_steps     (r_steps),
        .i_advance   (axis_advance),
        .o_pos       (pos_y)
    );

    // Frame store port: sweep, draw point or read cell.
    always_comb begin
        ram_col   = r_cx;
        ram_row   = r_cy;
        ram_we    = 1'b0;
        ram_wdata = r_value;
        unique case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_DRAW: begin
                ram_col = XW'(pos_x[PB-2:0]);
                ram_row = YW'(pos_y[PB-2:0]);
                ram_we  = draw_in;
            end
            ST_READ, ST_RWAIT: begin
                ram_col = r_cell_x;
                ram_row = r_cell_y;
            end
            ST_IDLE, ST_DIVX, ST_DIVY: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_addr = AW'(AW'(ram_row) * AW'(MAX_WIDTH)) + AW'(ram_col);
    end

    dda_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_steps      = r_steps;
        n_cnt        = r_cnt;
        n_value      = r_value;
        n_mag_x      = r_mag_x;
        n_mag_y      = r_mag_y;
        n_cell_x     = r_cell_x;
        n_cell_y     = r_cell_y;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_points     = r_points;
        n_div_kick   = 1'b0;
        n_out_valid  = 1'b0;
        n_read_value = r_read_value;
        n_out_points = r_out_points;
        n_oor        = r_oor;

        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                if (sweep_last_x) begin
                    n_cx = '0;
                    n_cy = r_cy + 1'b1;
                end else begin
                    n_cx = r_cx + 1'b1;
                end
                if (sweep_last_x && sweep_last_y) begin
                    n_cx    = '0;
                    n_cy    = '0;
                    n_state = ST_IDLE;
                    if (r_state == ST_CLEAR) begin
                        n_out_valid  = 1'b1;
                        n_read_value = '0;
                        n_out_points = '0;
                        n_oor        = 1'b0;
                    end
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_value      = VALUE_BITS'(i_pixel_value);
                    n_read_value = '0;
                    n_out_points = '0;
                    n_oor        = 1'b0;
                    unique case (dda_pkg::t_req'(i_req_type))
                        dda_pkg::REQ_DRAW: begin
                            n_steps  = i_step_count;
                            n_cnt    = '0;
                            n_points = '0;
                            n_mag_x  = neg_x ? SB'(-dx) : SB'(dx);
                            n_mag_y  = neg_y ? SB'(-dy) : SB'(dy);
                            if (i_step_count == '0) begin
                                n_state = ST_DRAW;
                            end else begin
                                n_state    = ST_DIVX;
                                n_div_kick = 1'b1;
                            end
                        end
                        dda_pkg::REQ_CLEAR: begin
                            n_cx = '0;
                            n_cy = '0;
                            if ((act_w == '0) || (act_h == '0)) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_CLEAR;
                            end
                        end
                        dda_pkg::REQ_READ: begin
                            n_cell_x = XW'(i_cell_x);
                            n_cell_y = YW'(i_cell_y);
                            if (read_oor) begin
                                n_out_valid = 1'b1;
                                n_oor       = 1'b1;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                        dda_pkg::REQ_NONE: begin
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    n_state    = ST_DIVY;
                    n_div_kick = 1'b1;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                n_points = r_points + NB'(draw_in);
                if (r_cnt == r_steps) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_points = r_points + NB'(draw_in);
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_RWAIT;
            end
            ST_RWAIT: begin
                n_state      = ST_IDLE;
                n_out_valid  = 1'b1;
                n_read_value = PXB'(ram_rdata);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_grid_width  <= dda_pkg::GRID_WIDTH_RESET;
            r_grid_height <= dda_pkg::GRID_HEIGHT_RESET;
            r_cx          <= '0;
            r_cy          <= '0;
            r_div_kick    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_div_kick  <= n_div_kick;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dda_pkg::CFG_GRID_WIDTH: begin
                        r_grid_width <= i_cfg_wdata[dda_pkg::GW_BITS-1:0];
                    end
                    dda_pkg::CFG_GRID_HEIGHT: begin
                        r_grid_height <= i_cfg_wdata[dda_pkg::GH_BITS-1:0];
                    end
                    default: begin
                        r_grid_width <= r_grid_width;
                    end
                endcase
            end
        end
        r_steps      <= n_steps;
        r_cnt        <= n_cnt;
        r_value      <= n_value;
        r_mag_x      <= n_mag_x;
        r_mag_y      <= n_mag_y;
        r_cell_x     <= n_cell_x;
        r_cell_y     <= n_cell_y;
        r_points     <= n_points;
        r_read_value <= n_read_value;
        r_out_points <= n_out_points;
        r_oor        <= n_oor;
    end

    assign o_result_valid      = r_out_valid;
    assign o_read_value        = r_read_value;
    assign o_points_written    = r_out_points;
    assign o_read_out_of_range = r_oor;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("frame store written while idle");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");

    a_points_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (r_points <= {1'b0, r_cnt}))
        else $error("point count ahead of step index");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == ST_DIVX) || (r_state == ST_DIVY)))
        else $error("divider finished outside a divide state");

    a_oor_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_oor) |-> ((r_read_value == '0) && (r_out_points == '0)))
        else $error("out-of-range read with nonzero fields");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Drives draw, clear, read and undefined requests through the start/busy port
// under random sender bursts and gaps, and reprograms the grid size between
// phases. A scoreboard keeps its own frame store and grid size, predicts
// every result and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb;
    import dda_pkg::*;

    localparam int QUIET_LIMIT = 40000;
    localparam int PHASE_ITEMS = 40;
    localparam int PHASES      = 7;

    typedef struct packed {
        t_req                         kind;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic [STEP_BITS-1:0]         steps;
        logic [PIXEL_BITS-1:0]        value;
        logic [CELLX_BITS-1:0]        cx;
        logic [CELLY_BITS-1:0]        cy;
    } t_raster_req;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] rdata;
        logic [COUNT_BITS-1:0] points;
        logic                  oor;
    } t_raster_result;

    class raster_scoreboard;
        localparam int COLS = 128;
        localparam int ROWS = 64;

        logic [PIXEL_BITS-1:0] cells [COLS*ROWS];
        int                    cols_reg;
        int                    rows_reg;
        t_raster_result        results_due [$];
        int                    errors;

        function new();
            foreach (cells[k]) cells[k] = '0;
            cols_reg = 128;
            rows_reg = 64;
            errors   = 0;
        endfunction

        function void set_grid(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_GRID_WIDTH) begin
                cols_reg = int'(data);
            end else if (idx == CFG_GRID_HEIGHT) begin
                rows_reg = int'(data[GH_BITS-1:0]);
            end
        endfunction

        function int active_cols();
            return (cols_reg > COLS) ? COLS : cols_reg;
        endfunction

        function int active_rows();
            return (rows_reg > ROWS) ? ROWS : rows_reg;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t ns: mismatch: %s", $time, msg);
            end
        endfunction

        function void record_request(t_raster_req r);
            t_raster_result res;
            int             w;
            int             h;
            int             i;
            int             n;
            longint         dx;
            longint         dy;
            longint         x;
            longint         y;
            res = '0;
            w = active_cols();
            h = active_rows();
            case (r.kind)
                REQ_DRAW: begin
                    dx = longint'(r.ex) - longint'(r.sx);
                    dy = longint'(r.ey) - longint'(r.sy);
                    n  = 0;
                    for (i = 0; i <= int'(r.steps); i++) begin
                        x = longint'(r.sx);
                        y = longint'(r.sy);
                        if (r.steps != 0) begin
                            x += (longint'(i) * dx) / longint'(r.steps);
                            y += (longint'(i) * dy) / longint'(r.steps);
                        end
                        if (x >= 0 && x < w && y >= 0 && y < h) begin
                            cells[int'(y) * COLS + int'(x)] = r.value;
                            n++;
                        end
                    end
                    res.points = COUNT_BITS'(n);
                end
                REQ_CLEAR: begin
                    for (int yy = 0; yy < h; yy++) begin
                        for (int xx = 0; xx < w; xx++) begin
                            cells[yy * COLS + xx] = r.value;
                        end
                    end
                end
                REQ_READ: begin
                    if (int'(r.cx) < w && int'(r.cy) < h) begin
                        res.rdata = cells[int'(r.cy) * COLS + int'(r.cx)];
                    end else begin
                        res.oor = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            results_due.insert(results_due.size(), res);
        endfunction

        function void check_result(logic [PIXEL_BITS-1:0] rdata, logic [COUNT_BITS-1:0] points,
                                   logic oor);
            t_raster_result want;
            if (results_due.size() == 0) begin
                log_error($sformatf("unexpected result read_value %0d points_written %0d oor %0d",
                                    rdata, points, oor));
                return;
            end
            want = results_due.pop_front();
            if (rdata !== want.rdata || points !== want.points || oor !== want.oor) begin
                log_error($sformatf({"exp read_value %0d points_written %0d oor %0d, ",
                                     "got read_value %0d points_written %0d oor %0d"},
                                    want.rdata, want.points, want.oor, rdata, points, oor));
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_raster_req              req_drv;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     o_result_valid;
    logic [PIXEL_BITS-1:0]    o_read_value;
    logic [COUNT_BITS-1:0]    o_points_written;
    logic                     o_read_out_of_range;

    raster_scoreboard sb;
    int               burst_left;
    int               cur_w;
    int               cur_h;

    dda_line_rasterizer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (req_drv.kind),
        .i_start_x           (req_drv.sx),
        .i_start_y           (req_drv.sy),
        .i_end_x             (req_drv.ex),
        .i_end_y             (req_drv.ey),
        .i_step_count        (req_drv.steps),
        .i_pixel_value       (req_drv.value),
        .i_cell_x            (req_drv.cx),
        .i_cell_y            (req_drv.cy),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_result_valid      (o_result_valid),
        .o_read_value        (o_read_value),
        .o_points_written    (o_points_written),
        .o_read_out_of_range (o_read_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                sb.check_result(o_read_value, o_points_written, o_read_out_of_range);
            end
            if (start && !busy) begin
                sb.record_request(req_drv);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || o_result_valid || (start && !busy)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** dda_line_rasterizer: FAILED **");
        $finish;
    end

    function automatic t_raster_req make_draw(int sx, int sy, int ex, int ey, int steps,
                                              int value);
        t_raster_req r;
        r       = '0;
        r.kind  = REQ_DRAW;
        r.sx    = COORD_BITS'(sx);
        r.sy    = COORD_BITS'(sy);
        r.ex    = COORD_BITS'(ex);
        r.ey    = COORD_BITS'(ey);
        r.steps = STEP_BITS'(steps);
        r.value = PIXEL_BITS'(value);
        return r;
    endfunction

    function automatic t_raster_req make_read(int cx, int cy);
        t_raster_req r;
        r      = '0;
        r.kind = REQ_READ;
        r.cx   = CELLX_BITS'(cx);
        r.cy   = CELLY_BITS'(cy);
        return r;
    endfunction

    function automatic t_raster_req make_clear(int value);
        t_raster_req r;
        r       = '0;
        r.kind  = REQ_CLEAR;
        r.value = PIXEL_BITS'(value);
        return r;
    endfunction

    function automatic int near_coord(int span);
        return int'($urandom_range(0, span + 39)) - 20;
    endfunction

    function automatic t_raster_req random_request();
        t_raster_req r;
        int          pick;
        int          mode;
        r.sx    = COORD_BITS'($urandom);
        r.sy    = COORD_BITS'($urandom);
        r.ex    = COORD_BITS'($urandom);
        r.ey    = COORD_BITS'($urandom);
        r.steps = STEP_BITS'($urandom);
        r.value = PIXEL_BITS'($urandom);
        r.cx    = CELLX_BITS'($urandom);
        r.cy    = CELLY_BITS'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 50) begin
            r.kind = REQ_DRAW;
            mode   = $urandom_range(0, 19);
            if (mode != 0) begin
                r.sx = COORD_BITS'(near_coord(cur_w));
                r.sy = COORD_BITS'(near_coord(cur_h));
                r.ex = COORD_BITS'(near_coord(cur_w));
                r.ey = COORD_BITS'(near_coord(cur_h));
                if (mode < 3) begin
                    r.steps = '0;
                end else if (mode < 5) begin
                    r.steps = STEP_BITS'($urandom_range(150, 1200));
                end else begin
                    r.steps = STEP_BITS'($urandom_range(1, 120));
                end
            end
        end else if (pick < 85) begin
            r.kind = REQ_READ;
            if ($urandom_range(0, 1) == 1 && cur_w > 0 && cur_h > 0) begin
                r.cx = CELLX_BITS'($urandom_range(0, cur_w - 1));
                r.cy = CELLY_BITS'($urandom_range(0, cur_h - 1));
            end
        end else if (pick < 92) begin
            r.kind = REQ_CLEAR;
        end else begin
            r.kind = REQ_NONE;
        end
        return r;
    endfunction

    task automatic send_request(input t_raster_req r);
        @(negedge i_clk);
        req_drv = r;
        start   = 1'b1;
        do @(posedge i_clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 8);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_grid(idx, data);
        cur_w = sb.active_cols();
        cur_h = sb.active_rows();
    endtask

    initial begin : stimulus
        t_raster_req              r;
        logic [CFG_DATA_BITS-1:0] w_cfg;
        logic [CFG_DATA_BITS-1:0] h_cfg;
        int                       phase;
        int                       n;
        sb          = new();
        start       = 1'b0;
        req_drv     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_GRID_WIDTH;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        burst_left  = 4;
        cur_w       = 128;
        cur_h       = 64;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_grid(CFG_GRID_WIDTH, 8'd128);
        write_grid(CFG_GRID_HEIGHT, 8'd64);
        send_request(make_read(0, 0));
        send_request(make_read(127, 63));
        send_request(make_draw(5, 5, 90, -7, 0, 8'hFF));
        send_request(make_read(5, 5));
        send_request(make_draw(-2048, -2048, 2047, 2047, 4095, 8'h80));
        send_request(make_read(10, 10));
        send_request(make_draw(2047, -2048, -2048, 2047, 4095, 8'h01));
        send_request(make_draw(0, 63, 127, 0, 127, 8'h55));
        send_request(make_read(127, 0));
        send_request(make_draw(10, 20, 12, 20, 9, 8'h3C));
        send_request(make_draw(100, 40, 20, 3, 37, 8'hC3));
        send_request(make_read(20, 3));
        r      = random_request();
        r.kind = REQ_NONE;
        send_request(r);
        send_request(make_clear(8'hAA));
        send_request(make_read(64, 32));
        drain();
        write_grid(CFG_GRID_WIDTH, 8'd100);
        write_grid(CFG_GRID_HEIGHT, 8'd50);
        send_request(make_read(100, 0));
        send_request(make_read(99, 49));
        send_request(make_read(0, 50));
        send_request(make_draw(-5, -5, 130, 70, 135, 8'h7E));
        send_request(make_clear(8'h11));
        send_request(make_read(99, 49));
        drain();
        write_grid(CFG_GRID_WIDTH, 8'd0);
        send_request(make_read(0, 0));
        send_request(make_draw(0, 0, 0, 0, 0, 8'h22));
        send_request(make_clear(8'h33));

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    w_cfg = 8'd128;
                    h_cfg = 8'd64;
                end
                1: begin
                    w_cfg = 8'hFF;
                    h_cfg = 8'hFF;
                end
                2: begin
                    w_cfg = 8'd0;
                    h_cfg = 8'($urandom_range(1, 64));
                end
                3: begin
                    w_cfg = 8'($urandom_range(1, 128));
                    h_cfg = 8'h80;
                end
                4: begin
                    w_cfg = 8'd1;
                    h_cfg = 8'h81;
                end
                5: begin
                    w_cfg = 8'($urandom_range(1, 128));
                    h_cfg = 8'($urandom_range(1, 64));
                end
                default: begin
                    w_cfg = 8'($urandom);
                    h_cfg = 8'($urandom);
                end
            endcase
            write_grid(CFG_GRID_WIDTH, w_cfg);
            write_grid(CFG_GRID_HEIGHT, h_cfg);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_request());
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** dda_line_rasterizer: PASSED **");
        end else begin
            $display("** dda_line_rasterizer: FAILED **");
        end
        $finish;
    end
endmodule
